// ===== sv/kans_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and a helper function of the key-aware note speller.
package kans_pkg;

  localparam int NUM_SCALES   = 14;
  localparam int NUM_LETTERS  = 7;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 4;
  localparam int COST_W       = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 4'd1;

  localparam logic [3:0] SCALE_CHROMATIC = 4'd13;

  localparam logic [COST_W-1:0] COST_STEP   = 6'd10;
  localparam logic [COST_W-1:0] COST_DOUBLE = 6'd20;
  localparam logic [COST_W-1:0] COST_NONE   = 6'd63;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic signed [2:0] alter_t;
  typedef logic signed [1:0] small_t;
  typedef logic signed [3:0] keysig_t;

  localparam logic [11:0] SCALE_MASK [NUM_SCALES] = '{
    12'hAB5, 12'h5AD, 12'h9AD, 12'hAAD, 12'h6AD, 12'h5AB, 12'hAD5,
    12'h6B5, 12'h56B, 12'h295, 12'h4A9, 12'h4E9, 12'h555, 12'hFFF
  };

  localparam logic [3:0] REL_MAJOR_OFFSET [NUM_SCALES] = '{
    4'd0, 4'd3, 4'd3, 4'd3, 4'd10, 4'd8, 4'd7, 4'd5, 4'd1, 4'd0, 4'd3, 4'd3, 4'd0, 4'd0
  };

  localparam keysig_t KEY_SIG_OF_MAJOR [12] = '{
    4'sd0, -4'sd5, 4'sd2, -4'sd3, 4'sd4, -4'sd1, 4'sd6, 4'sd1, -4'sd4, 4'sd3, -4'sd2, 4'sd5
  };

  localparam logic [3:0] LETTER_PC [NUM_LETTERS] = '{
    4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
  };

  localparam logic [2:0] SHARP_SEQ [NUM_LETTERS] = '{
    3'd3, 3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6
  };

  localparam logic [2:0] FLAT_SEQ [NUM_LETTERS] = '{
    3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0, 3'd3
  };

  // Key alteration of one letter under a key signature.
  function automatic small_t key_alter(input logic [2:0] letter, input keysig_t ks);
    logic [3:0] mag;
    small_t r;
    mag = ks[3] ? 4'(-ks) : 4'(ks);
    r = 2'sd0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (4'(i) < mag) begin
        if (!ks[3] && SHARP_SEQ[i] == letter) begin
          r = 2'sd1;
        end
        if (ks[3] && FLAT_SEQ[i] == letter) begin
          r = -2'sd1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/kans_if.sv =====
`timescale 1ns / 1ps
// Request channels of the note speller: note requests in, spelled results out.
interface kans_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] midi_note;

  modport source (output valid, midi_note, input ready);
  modport sink (input valid, midi_note, output ready);
  modport monitor (input valid, ready, midi_note);
endinterface

interface kans_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        letter;
  logic signed [2:0] alteration;
  logic signed [4:0] octave_number;
  logic              needs_accidental;
  logic              in_scale;
  logic [3:0]        interval_from_root;
  logic [3:0]        degree_code;

  modport source (output valid, letter, alteration, octave_number, needs_accidental,
                  in_scale, interval_from_root, degree_code, input ready);
  modport sink (input valid, letter, alteration, octave_number, needs_accidental,
                in_scale, interval_from_root, degree_code, output ready);
  modport monitor (input valid, ready, letter, alteration, octave_number, needs_accidental,
                   in_scale, interval_from_root, degree_code);
endinterface

// ===== sv/key_aware_note_speller.sv =====
`timescale 1ns / 1ps
// Top level of the key-aware note speller: a three-stage spelling pipeline.
//
// Spells one MIDI note per request in the key set by the root and scale registers and
// classifies it against that scale. The pipeline has three register stages (note split
// and key lookup, per-letter scoring, best-letter pick into the output register), and
// one request is taken every cycle unless all stages are full and the result stalls.
// Each stage holds its request while the next one is full and stalled, so backpressure
// on the result channel reaches the note channel only when all stages are occupied.
// The user must write registers only with no request in flight, unchecked by the block.
module key_aware_note_speller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [kans_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kans_pkg::CFG_DATA_W-1:0]       cfg_data,
  kans_in_if.sink                               note_in,
  kans_out_if.source                            note_out
);

  logic [3:0] root_pitch_class;
  logic [3:0] scale_type;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // Stage 1 registers.
  logic [3:0]            s1_pc;
  logic [3:0]            s1_oct;
  logic [3:0]            s1_interval;
  logic [11:0]           s1_mask;
  kans_pkg::keysig_t     s1_ks;

  // Stage 2 registers.
  kans_pkg::cost_t       s2_cost [kans_pkg::NUM_LETTERS];
  kans_pkg::alter_t      s2_need [kans_pkg::NUM_LETTERS];
  kans_pkg::small_t      s2_wrap [kans_pkg::NUM_LETTERS];
  kans_pkg::small_t      s2_ka   [kans_pkg::NUM_LETTERS];
  logic [3:0]            s2_oct;
  logic [3:0]            s2_interval;
  logic                  s2_member;
  logic [3:0]            s2_degree;

  // Stage 1 logic.
  logic [12:0]           mul43;
  logic [3:0]            quot;
  logic [6:0]            pc_full;
  logic [3:0]            root_m;
  logic [3:0]            st_s;
  logic signed [4:0]     pc_diff;
  logic [4:0]            interval_w;
  logic [4:0]            ks_sum;
  logic [3:0]            ks_idx;

  always_comb begin
    mul43      = 13'(note_in.midi_note) * 13'd43;
    quot       = mul43[12:9];
    pc_full    = note_in.midi_note - 7'(quot) * 7'd12;
    root_m     = (root_pitch_class >= 4'd12) ? root_pitch_class - 4'd12 : root_pitch_class;
    st_s       = (scale_type > kans_pkg::SCALE_CHROMATIC) ? kans_pkg::SCALE_CHROMATIC
                                                           : scale_type;
    pc_diff    = $signed({1'b0, pc_full[3:0]}) - $signed({1'b0, root_m});
    interval_w = pc_diff[4] ? 5'(pc_diff + 5'sd12) : 5'(pc_diff);
    ks_sum     = 5'(root_m) + 5'(kans_pkg::REL_MAJOR_OFFSET[st_s]);
    ks_idx     = (ks_sum >= 5'd12) ? 4'(ks_sum - 5'd12) : ks_sum[3:0];
  end

  // Stage 2 logic.
  kans_pkg::cost_t   cost_c [kans_pkg::NUM_LETTERS];
  kans_pkg::alter_t  need_c [kans_pkg::NUM_LETTERS];
  kans_pkg::small_t  wrap_c [kans_pkg::NUM_LETTERS];
  kans_pkg::small_t  ka_c   [kans_pkg::NUM_LETTERS];
  logic              member_c;
  logic [3:0]        degree_c;

  always_comb begin
    logic signed [4:0] d;
    logic signed [4:0] n;
    logic signed [3:0] dd;
    logic [2:0]        nmag;
    logic [2:0]        dmag;
    kans_pkg::cost_t   c;
    for (int l = 0; l < kans_pkg::NUM_LETTERS; l++) begin
      d = $signed({1'b0, s1_pc}) - $signed({1'b0, kans_pkg::LETTER_PC[l]});
      if (d > 5'sd6) begin
        n = d - 5'sd12;
        wrap_c[l] = 2'sd1;
      end else if (d < -5'sd6) begin
        n = d + 5'sd12;
        wrap_c[l] = -2'sd1;
      end else begin
        n = d;
        wrap_c[l] = 2'sd0;
      end
      ka_c[l]   = kans_pkg::key_alter(3'(l), s1_ks);
      need_c[l] = n[2:0];
      nmag      = n[4] ? 3'(-n) : n[2:0];
      dd        = 4'(n) - 4'(ka_c[l]);
      dmag      = dd[3] ? 3'(-dd) : dd[2:0];
      c         = 6'(dmag) * kans_pkg::COST_STEP + 6'(nmag);
      if (nmag == 3'd2) begin
        c = c + kans_pkg::COST_DOUBLE;
      end
      if (nmag != 3'd0 && (n[4] != s1_ks[3])) begin
        c = c + 6'd1;
      end
      cost_c[l] = (nmag > 3'd2) ? kans_pkg::COST_NONE : c;
    end
    member_c = s1_mask[s1_interval];
    if (!member_c) begin
      degree_c = 4'd0;
    end else if (s1_interval == 4'd6 && !s1_mask[5]) begin
      degree_c = 4'd12;
    end else begin
      degree_c = s1_interval;
    end
  end

  // Stage 3 logic: first lowest cost wins.
  logic [2:0] best_c;

  always_comb begin
    kans_pkg::cost_t best_cost;
    best_c    = 3'd0;
    best_cost = s2_cost[0];
    for (int l = 1; l < kans_pkg::NUM_LETTERS; l++) begin
      if (s2_cost[l] < best_cost) begin
        best_cost = s2_cost[l];
        best_c    = 3'(l);
      end
    end
  end

  assign rdy3 = !v3 || note_out.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign note_in.ready  = rdy1;
  assign note_out.valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_pitch_class <= '0;
      scale_type       <= '0;
      v1               <= 1'b0;
      v2               <= 1'b0;
      v3               <= 1'b0;
    end else begin
      if (cfg_write_en && cfg_index == kans_pkg::REG_ROOT) begin
        root_pitch_class <= cfg_data;
      end
      if (cfg_write_en && cfg_index == kans_pkg::REG_SCALE) begin
        scale_type <= cfg_data;
      end
      if (rdy1) begin
        v1 <= note_in.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && note_in.valid) begin
      s1_pc       <= pc_full[3:0];
      s1_oct      <= quot;
      s1_interval <= interval_w[3:0];
      s1_mask     <= kans_pkg::SCALE_MASK[st_s];
      s1_ks       <= kans_pkg::KEY_SIG_OF_MAJOR[ks_idx];
    end
    if (rdy2 && v1) begin
      s2_cost     <= cost_c;
      s2_need     <= need_c;
      s2_wrap     <= wrap_c;
      s2_ka       <= ka_c;
      s2_oct      <= s1_oct;
      s2_interval <= s1_interval;
      s2_member   <= member_c;
      s2_degree   <= degree_c;
    end
    if (rdy3 && v2) begin
      note_out.letter             <= best_c;
      note_out.alteration         <= s2_need[best_c];
      note_out.octave_number      <= $signed({1'b0, s2_oct}) - 5'sd1
                                     + 5'(s2_wrap[best_c]);
      note_out.needs_accidental   <= (s2_need[best_c] != 3'(s2_ka[best_c]));
      note_out.in_scale           <= s2_member;
      note_out.interval_from_root <= s2_interval;
      note_out.degree_code        <= s2_degree;
    end
  end

endmodule

// ===== sv/kans_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions of the note speller and their binding to the top level.
module kans_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic [2:0]        letter,
  input logic signed [2:0] alteration,
  input logic              in_scale,
  input logic [3:0]        interval_from_root,
  input logic [3:0]        degree_code
);

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("Result valid right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(letter))
    else $error("Stalled result changed or dropped.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> letter <= 3'd6 && interval_from_root <= 4'd11
                     && degree_code <= 4'd12)
    else $error("Letter, interval or degree out of range.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> alteration >= -3'sd2 && alteration <= 3'sd2)
    else $error("Alteration out of range.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !in_scale |-> degree_code == 4'd0)
    else $error("Degree given for a note outside the scale.");

endmodule

bind key_aware_note_speller kans_checker u_kans_checker (
  .clk                (clk),
  .rst                (rst),
  .result_valid       (note_out.valid),
  .result_ready       (note_out.ready),
  .letter             (note_out.letter),
  .alteration         (note_out.alteration),
  .in_scale           (note_out.in_scale),
  .interval_from_root (note_out.interval_from_root),
  .degree_code        (note_out.degree_code)
);
